/* sv/pcl_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcl_pkg
// Types, codes and constants shared by the pedestrian crossing light files.
// ----------------------------------------------------------------------------
package pcl_pkg;

   localparam int unsigned CountWidth = 8;
   localparam int unsigned LampCount  = 5;
   localparam int unsigned CsrIndexWidth = 2;

   localparam logic [CountWidth-1:0] ElapsedMax      = 8'd255;
   localparam logic [CountWidth-1:0] CountdownLimit  = 8'd10;
   localparam logic [CountWidth-1:0] MinGreenReset   = 8'd5;
   localparam logic [CountWidth-1:0] AmberReset      = 8'd5;
   localparam logic [CountWidth-1:0] WalkReset       = 8'd20;

   // lamp bit positions
   localparam int unsigned LampWalk     = 0;
   localparam int unsigned LampDontWalk = 1;
   localparam int unsigned LampGreen    = 2;
   localparam int unsigned LampAmber    = 3;
   localparam int unsigned LampRed      = 4;

   localparam logic [LampCount-1:0] LampReset = 5'b00110;

   typedef enum logic [1:0] {
      PED_STOP    = 2'd0,
      PED_TRANSIT = 2'd1,
      PED_WALK    = 2'd2
   } ped_phase_type;

   typedef enum logic [1:0] {
      CAR_GREEN  = 2'd0,
      CAR_YELLOW = 2'd1,
      CAR_RED    = 2'd2
   } car_phase_type;

   typedef enum logic [1:0] {
      MSG_NONE  = 2'd0,
      MSG_CROSS = 2'd1,
      MSG_WAIT  = 2'd2
   } msg_type;

   typedef enum logic [CsrIndexWidth-1:0] {
      CSR_MIN_GREEN = 2'd0,
      CSR_AMBER     = 2'd1,
      CSR_WALK      = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [CountWidth-1:0] min_green_ticks;
      logic [CountWidth-1:0] amber_ticks;
      logic [CountWidth-1:0] walk_ticks;
   } cfg_type;

   typedef struct packed {
      ped_phase_type         ped_phase;
      car_phase_type         car_phase;
      logic [CountWidth-1:0] ped_phase_count;
      logic [CountWidth-1:0] car_phase_count;
      logic [CountWidth-1:0] ped_green_elapsed;
      logic [CountWidth-1:0] car_green_elapsed;
      logic [LampCount-1:0]  lamp_bits;
   } state_type;

   typedef struct packed {
      logic       walk_lamp;
      logic       dont_walk_lamp;
      logic       car_green_lamp;
      logic       car_amber_lamp;
      logic       car_red_lamp;
      logic [3:0] countdown_digit;
      logic       countdown_valid;
      msg_type    message_event;
   } result_type;

   function automatic logic [CountWidth-1:0] sat_inc(input logic [CountWidth-1:0] v);
      logic [CountWidth-1:0] r;
      r = (v < ElapsedMax) ? v + 8'd1 : ElapsedMax;
      return r;
   endfunction

endpackage

/* sv/pcl_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcl channel interfaces
// Valid/ready channels for button ticks, lamp results and register writes.
// ----------------------------------------------------------------------------
interface pcl_req_if;
   logic valid;
   logic ready;
   logic button_pressed;

   modport source (output valid, output button_pressed, input ready);
   modport sink   (input valid, input button_pressed, output ready);
endinterface

interface pcl_rsp_if;
   logic       valid;
   logic       ready;
   logic       walk_lamp;
   logic       dont_walk_lamp;
   logic       car_green_lamp;
   logic       car_amber_lamp;
   logic       car_red_lamp;
   logic [3:0] countdown_digit;
   logic       countdown_valid;
   logic [1:0] message_event;

   modport source (output valid, output walk_lamp, output dont_walk_lamp,
                   output car_green_lamp, output car_amber_lamp, output car_red_lamp,
                   output countdown_digit, output countdown_valid,
                   output message_event, input ready);
   modport sink   (input valid, input walk_lamp, input dont_walk_lamp,
                   input car_green_lamp, input car_amber_lamp, input car_red_lamp,
                   input countdown_digit, input countdown_valid,
                   input message_event, output ready);
endinterface

interface pcl_csr_if;
   logic       valid;
   logic       ready;
   logic [1:0] index;
   logic [7:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

/* sv/pcl_step.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcl_step
// One tick of the pedestrian and car machines: next state and result item.
// ----------------------------------------------------------------------------
module pcl_step (
   input  pcl_pkg::cfg_type    cfg,
   input  pcl_pkg::state_type  state,
   input  logic                pressed,
   output pcl_pkg::state_type  state_next,
   output pcl_pkg::result_type result
);

   logic [pcl_pkg::CountWidth-1:0] ped_count_inc;
   logic [pcl_pkg::CountWidth-1:0] ped_count_dec;
   logic [pcl_pkg::CountWidth-1:0] car_count_inc;
   logic [pcl_pkg::CountWidth-1:0] ped_elapsed_inc;
   logic [pcl_pkg::CountWidth-1:0] car_elapsed_inc;

   assign ped_count_inc   = state.ped_phase_count + 8'd1;
   assign ped_count_dec   = state.ped_phase_count - 8'd1;
   assign car_count_inc   = state.car_phase_count + 8'd1;
   assign ped_elapsed_inc = pcl_pkg::sat_inc(state.ped_green_elapsed);
   assign car_elapsed_inc = pcl_pkg::sat_inc(state.car_green_elapsed);

   // pedestrian machine
   always_comb begin
      state_next = state;
      result.countdown_digit = 4'd0;
      result.countdown_valid = 1'b0;
      result.message_event   = pcl_pkg::MSG_NONE;

      unique case (state.ped_phase)
         pcl_pkg::PED_STOP: begin
            state_next.ped_green_elapsed = ped_elapsed_inc;
            state_next.lamp_bits[pcl_pkg::LampDontWalk] = 1'b1;
            state_next.lamp_bits[pcl_pkg::LampWalk]     = 1'b0;
            if (pressed && (ped_elapsed_inc > cfg.min_green_ticks)) begin
               state_next.ped_phase       = pcl_pkg::PED_TRANSIT;
               state_next.ped_phase_count = '0;
            end
         end
         pcl_pkg::PED_TRANSIT: begin
            state_next.ped_phase_count = ped_count_inc;
            if (ped_count_inc >= cfg.amber_ticks) begin
               state_next.ped_phase       = pcl_pkg::PED_WALK;
               state_next.ped_phase_count = cfg.walk_ticks;
               result.message_event       = pcl_pkg::MSG_CROSS;
            end
         end
         pcl_pkg::PED_WALK: begin
            state_next.lamp_bits[pcl_pkg::LampWalk]     = 1'b1;
            state_next.lamp_bits[pcl_pkg::LampDontWalk] = 1'b0;
            state_next.ped_phase_count = ped_count_dec;
            if (ped_count_dec != '0) begin
               if (ped_count_dec < pcl_pkg::CountdownLimit) begin
                  result.countdown_digit = ped_count_dec[3:0];
                  result.countdown_valid = 1'b1;
               end
            end else begin
               state_next.ped_phase         = pcl_pkg::PED_STOP;
               state_next.ped_green_elapsed = '0;
               result.message_event         = pcl_pkg::MSG_WAIT;
            end
         end
         default: begin
         end
      endcase

      // car machine
      unique case (state.car_phase)
         pcl_pkg::CAR_GREEN: begin
            state_next.lamp_bits[pcl_pkg::LampGreen] = 1'b1;
            state_next.lamp_bits[pcl_pkg::LampAmber] = 1'b0;
            state_next.lamp_bits[pcl_pkg::LampRed]   = 1'b0;
            state_next.car_green_elapsed = car_elapsed_inc;
            if (pressed && (car_elapsed_inc > cfg.min_green_ticks)) begin
               state_next.car_phase       = pcl_pkg::CAR_YELLOW;
               state_next.car_phase_count = '0;
               state_next.lamp_bits[pcl_pkg::LampAmber] = 1'b1;
               state_next.lamp_bits[pcl_pkg::LampGreen] = 1'b0;
            end
         end
         pcl_pkg::CAR_YELLOW: begin
            state_next.car_phase_count = car_count_inc;
            if (car_count_inc >= cfg.amber_ticks) begin
               state_next.car_phase       = pcl_pkg::CAR_RED;
               state_next.car_phase_count = '0;
               state_next.lamp_bits[pcl_pkg::LampRed]   = 1'b1;
               state_next.lamp_bits[pcl_pkg::LampAmber] = 1'b0;
            end
         end
         pcl_pkg::CAR_RED: begin
            state_next.car_phase_count = car_count_inc;
            if (car_count_inc >= cfg.walk_ticks) begin
               state_next.car_phase         = pcl_pkg::CAR_GREEN;
               state_next.car_phase_count   = '0;
               state_next.car_green_elapsed = '0;
            end
         end
         default: begin
         end
      endcase

      result.walk_lamp      = state_next.lamp_bits[pcl_pkg::LampWalk];
      result.dont_walk_lamp = state_next.lamp_bits[pcl_pkg::LampDontWalk];
      result.car_green_lamp = state_next.lamp_bits[pcl_pkg::LampGreen];
      result.car_amber_lamp = state_next.lamp_bits[pcl_pkg::LampAmber];
      result.car_red_lamp   = state_next.lamp_bits[pcl_pkg::LampRed];
   end

endmodule

/* sv/pedestrian_crossing_lights.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pedestrian_crossing_lights
// Pedestrian crossing controller: walk/transit/stop and green/amber/red
// machines stepped once per tick item, with walk countdown and message events.
// ----------------------------------------------------------------------------
// Each accepted req item is one tick with the button level; it produces
// exactly one rsp item holding the lamp states after that tick, the walk
// countdown digit and any cross or wait message event. The step logic is
// combinational and sits between the phase/counter registers and a
// single output register, so a new item is taken every cycle while the
// output register is empty or being drained. Register writes on csr are
// always accepted and should be made while no tick is in flight.
module pedestrian_crossing_lights (
   input logic         clock,
   input logic         reset,
   pcl_req_if.sink     req_ch,
   pcl_rsp_if.source   rsp_ch,
   pcl_csr_if.sink     csr_ch
);

   pcl_pkg::cfg_type    cfg_ff,   cfg_in;
   pcl_pkg::state_type  state_ff, state_in;
   pcl_pkg::state_type  state_step;
   pcl_pkg::result_type result_step;
   pcl_pkg::result_type rsp_data_ff, rsp_data_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                req_accept;

   assign req_ch.ready = !rsp_valid_ff || rsp_ch.ready;
   assign req_accept   = req_ch.valid && req_ch.ready;
   assign csr_ch.ready = 1'b1;

   pcl_step u_step (
      .cfg        (cfg_ff),
      .state      (state_ff),
      .pressed    (req_ch.button_pressed),
      .state_next (state_step),
      .result     (result_step)
   );

   // register writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_ch.valid) begin
         unique case (csr_ch.index)
            pcl_pkg::CSR_MIN_GREEN: cfg_in.min_green_ticks = csr_ch.data;
            pcl_pkg::CSR_AMBER:     cfg_in.amber_ticks     = csr_ch.data;
            pcl_pkg::CSR_WALK:      cfg_in.walk_ticks      = csr_ch.data;
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      state_in     = req_accept ? state_step : state_ff;
      rsp_data_in  = req_accept ? result_step : rsp_data_ff;
      rsp_valid_in = req_accept || (rsp_valid_ff && !rsp_ch.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.min_green_ticks   <= pcl_pkg::MinGreenReset;
         cfg_ff.amber_ticks       <= pcl_pkg::AmberReset;
         cfg_ff.walk_ticks        <= pcl_pkg::WalkReset;
         state_ff.ped_phase         <= pcl_pkg::PED_STOP;
         state_ff.car_phase         <= pcl_pkg::CAR_GREEN;
         state_ff.ped_phase_count   <= '0;
         state_ff.car_phase_count   <= '0;
         state_ff.ped_green_elapsed <= '0;
         state_ff.car_green_elapsed <= '0;
         state_ff.lamp_bits         <= pcl_pkg::LampReset;
         rsp_valid_ff <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_ch.valid           = rsp_valid_ff;
   assign rsp_ch.walk_lamp       = rsp_data_ff.walk_lamp;
   assign rsp_ch.dont_walk_lamp  = rsp_data_ff.dont_walk_lamp;
   assign rsp_ch.car_green_lamp  = rsp_data_ff.car_green_lamp;
   assign rsp_ch.car_amber_lamp  = rsp_data_ff.car_amber_lamp;
   assign rsp_ch.car_red_lamp    = rsp_data_ff.car_red_lamp;
   assign rsp_ch.countdown_digit = rsp_data_ff.countdown_digit;
   assign rsp_ch.countdown_valid = rsp_data_ff.countdown_valid;
   assign rsp_ch.message_event   = rsp_data_ff.message_event;

   // exactly one car lamp lit at any time
   a_car_lamp_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot(state_ff.lamp_bits[pcl_pkg::LampRed:pcl_pkg::LampGreen]))
      else $error("car lamps not one-hot");

   // exactly one pedestrian lamp lit at any time
   a_ped_lamp_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot(state_ff.lamp_bits[pcl_pkg::LampDontWalk:pcl_pkg::LampWalk]))
      else $error("pedestrian lamps not one-hot");

   // every accepted tick leaves a result item in the output register
   a_accept_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> rsp_valid_ff)
      else $error("accepted item produced no result");

   // countdown only during walk, and the digit is blank otherwise
   a_countdown_in_walk: assert property (@(posedge clock) disable iff (reset)
      req_accept && result_step.countdown_valid |-> state_ff.ped_phase == pcl_pkg::PED_WALK)
      else $error("countdown outside walk");

endmodule
